// ===== rtl/core/jvm_int_bytecode_executor_macros.svh =====
// Assertion macros for the bytecode executor.
// No dependencies.
`ifndef JVM_INT_BYTECODE_EXECUTOR_MACROS_SVH
`define JVM_INT_BYTECODE_EXECUTOR_MACROS_SVH
// Implication checked every edge outside reset.
`define JVX_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define JVX_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/jvx_pkg.sv =====
// Package for the bytecode executor: widths, opcodes, payload types.
// No dependencies.
`default_nettype none
package jvx_pkg;
  localparam int StackDepth = 16;
  localparam int LocalCount = 16;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int SIdxW = $clog2(StackDepth);
  localparam int LIdxW = $clog2(LocalCount);

  localparam logic [7:0] OP_NOP = 8'd0, OP_BIPUSH = 8'd16, OP_ILOAD = 8'd21,
    OP_ILOAD0 = 8'd26, OP_ISTORE = 8'd54, OP_ISTORE0 = 8'd59, OP_POP = 8'd87,
    OP_DUP = 8'd89, OP_DUPX1 = 8'd90, OP_IADD = 8'd96, OP_ISUB = 8'd100,
    OP_IMUL = 8'd104, OP_IINC = 8'd132, OP_I2B = 8'd145, OP_I2C = 8'd146,
    OP_I2S = 8'd147, OP_IFEQ = 8'd153, OP_ICMPEQ = 8'd159, OP_GOTO = 8'd167,
    OP_IRET = 8'd172, OP_ICONSTM1 = 8'd2, OP_ICONST0 = 8'd3;

  localparam logic [2:0] FLT_NONE = 3'd0, FLT_OPC = 3'd1, FLT_UNDER = 3'd2,
    FLT_OVER = 3'd3, FLT_LOCAL = 3'd4, FLT_PC = 3'd5;

  typedef enum logic [3:0] {
    K_NOP, K_PUSHC, K_LOAD, K_STORE, K_POP, K_DUP, K_DUPX1, K_ADD, K_SUB,
    K_MUL, K_IINC, K_CAST, K_IF1, K_IF2, K_GOTO, K_RET
  } kind_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        branch_taken;
    logic signed [31:0] top_value;
    logic [4:0]  stack_depth;
    logic        returned;
    logic [2:0]  fault;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        unknown;
    logic [1:0]  len;
    logic [1:0]  need;
    logic [7:0]  cmd;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [8:0]  lidx;
    logic [31:0] konst;
  } dec_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/jvx_front.sv =====
// Front end: accepts items, decodes the opcode into a classified item.
// Depends on jvx_pkg.
`default_nettype none
module jvx_front import jvx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire logic     in_push,
  output logic          in_full,
  output dec_item_t     dq_item,
  output logic          dq_valid,
  input  wire logic     dq_ready
);
  dec_item_t d;
  dec_item_t item_r, item_nxt;
  logic      valid_r, valid_nxt;
  logic [7:0] op;

  // decode
  always_comb begin
    op = in_item.cmd;
    d = '0;
    d.cmd = op; d.hi = in_item.operand_hi; d.lo = in_item.operand_lo;
    d.len = 2'd1; d.kind = K_NOP;
    d.konst = {{24{in_item.operand_hi[7]}}, in_item.operand_hi};
    priority if (op == OP_NOP) d.kind = K_NOP;
    else if (op >= OP_ICONSTM1 && op <= 8'd8) begin
      d.kind = K_PUSHC; d.konst = 32'(op) - 32'(OP_ICONST0);
    end else if (op == OP_BIPUSH) begin d.kind = K_PUSHC; d.len = 2'd2; end
    else if (op == OP_ILOAD) begin
      d.kind = K_LOAD; d.len = 2'd2; d.lidx = {1'b0, in_item.operand_hi};
    end else if (op >= OP_ILOAD0 && op <= 8'd29) begin
      d.kind = K_LOAD; d.lidx = 9'(op - OP_ILOAD0);
    end else if (op == OP_ISTORE) begin
      d.kind = K_STORE; d.len = 2'd2; d.need = 2'd1; d.lidx = {1'b0, in_item.operand_hi};
    end else if (op >= OP_ISTORE0 && op <= 8'd62) begin
      d.kind = K_STORE; d.need = 2'd1; d.lidx = 9'(op - OP_ISTORE0);
    end else if (op == OP_POP) begin d.kind = K_POP; d.need = 2'd1; end
    else if (op == OP_DUP) begin d.kind = K_DUP; d.need = 2'd1; end
    else if (op == OP_DUPX1) begin d.kind = K_DUPX1; d.need = 2'd2; end
    else if (op == OP_IADD) begin d.kind = K_ADD; d.need = 2'd2; end
    else if (op == OP_ISUB) begin d.kind = K_SUB; d.need = 2'd2; end
    else if (op == OP_IMUL) begin d.kind = K_MUL; d.need = 2'd2; end
    else if (op == OP_IINC) begin
      d.kind = K_IINC; d.len = 2'd3; d.lidx = {1'b0, in_item.operand_hi};
    end else if (op >= OP_I2B && op <= OP_I2S) begin d.kind = K_CAST; d.need = 2'd1; end
    else if (op >= OP_IFEQ && op <= 8'd158) begin
      d.kind = K_IF1; d.len = 2'd3; d.need = 2'd1;
    end else if (op >= OP_ICMPEQ && op <= 8'd164) begin
      d.kind = K_IF2; d.len = 2'd3; d.need = 2'd2;
    end else if (op == OP_GOTO) begin d.kind = K_GOTO; d.len = 2'd3; end
    else if (op >= OP_IRET && op <= 8'd177) d.kind = K_RET;
    else d.unknown = 1'b1;
  end

  // one-entry queue toward the back end
  assign in_full = valid_r && !dq_ready;
  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (dq_ready) valid_nxt = 1'b0;
    if (in_push && !in_full) begin valid_nxt = 1'b1; item_nxt = d; end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    item_r <= item_nxt;
  end
  assign dq_item = item_r;
  assign dq_valid = valid_r;
endmodule
`default_nettype wire

// ===== rtl/core/jvx_back.sv =====
// Back end: stack, locals, pc; one item per cycle while results drain.
// Depends on jvx_pkg and the assertion macro header.
`default_nettype none
`include "jvm_int_bytecode_executor_macros.svh"
module jvx_back import jvx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [15:0] meth_len,
  input  wire dec_item_t dq_item,
  input  wire logic      dq_valid,
  output logic           dq_ready,
  output out_item_t      out_item,
  output logic           out_empty,
  input  wire logic      out_pop
);
  logic [31:0] stk_r [StackDepth];
  logic [31:0] loc_r [LocalCount];
  logic [SpW-1:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic halted_r, halted_nxt;
  out_item_t res_r, res_nxt;
  logic full_r, full_nxt;
  logic go;
  logic [31:0] a, b, lv, wval, mul, tnew;
  logic [SIdxW-1:0] i1, i2, i0;
  logic [LIdxW-1:0] li;
  logic [2:0] flt, sel;
  logic cond, taken;
  logic signed [17:0] tgt;
  logic [17:0] pc_end;
  logic wr0, wr1, wr2, lwr;
  logic [31:0] w0, w1, w2, lw;

  assign dq_ready = !full_r || out_pop;
  assign go = dq_valid && dq_ready;
  assign i0 = SIdxW'(sp_r);
  assign i1 = SIdxW'(sp_r - SpW'(1));
  assign i2 = SIdxW'(sp_r - SpW'(2));
  assign a = stk_r[i1];
  assign b = stk_r[i2];
  assign li = LIdxW'(dq_item.lidx);
  assign lv = loc_r[li];
  assign mul = b * a;
  assign pc_end = 18'(pc_r) + 18'(dq_item.len);
  assign tgt = $signed({2'b00, pc_r}) + 18'($signed({dq_item.hi, dq_item.lo}));
  assign sel = 3'(dq_item.cmd - ((dq_item.kind == K_IF1) ? OP_IFEQ : OP_ICMPEQ));

  // condition test
  always_comb begin
    logic signed [31:0] x, y;
    x = (dq_item.kind == K_IF1) ? $signed(a) : $signed(b);
    y = (dq_item.kind == K_IF1) ? 32'sd0 : $signed(a);
    unique case (sel)
      3'd0: cond = x == y;
      3'd1: cond = x != y;
      3'd2: cond = x < y;
      3'd3: cond = x >= y;
      3'd4: cond = x > y;
      default: cond = x <= y;
    endcase
    if (dq_item.kind == K_GOTO) cond = 1'b1;
  end

  // execute
  always_comb begin
    logic grow1, grow2;
    grow1 = dq_item.kind == K_PUSHC || dq_item.kind == K_LOAD || dq_item.kind == K_DUP;
    grow2 = dq_item.kind == K_DUPX1;
    flt = FLT_NONE; taken = 1'b0;
    pc_nxt = pc_r; sp_nxt = sp_r; halted_nxt = halted_r;
    wr0 = 1'b0; wr1 = 1'b0; wr2 = 1'b0; lwr = 1'b0;
    w0 = a; w1 = a; w2 = b; lw = a; wval = a;
    if (!halted_r) begin
      priority if (pc_r >= meth_len) flt = FLT_PC;
      else if (dq_item.unknown) flt = FLT_OPC;
      else if (pc_end > 18'(meth_len)) flt = FLT_PC;
      else if (sp_r < SpW'(dq_item.need)) flt = FLT_UNDER;
      else if ((grow1 || grow2) && sp_r >= SpW'(StackDepth)) flt = FLT_OVER;
      else if (dq_item.lidx >= 9'(LocalCount)) flt = FLT_LOCAL;
      else if ((dq_item.kind == K_IF1 || dq_item.kind == K_IF2 ||
                dq_item.kind == K_GOTO) && cond &&
               (tgt < 0 || tgt >= $signed({2'b00, meth_len}))) flt = FLT_PC;
    end
    if (!halted_r && flt == FLT_NONE) begin
      pc_nxt = 16'(pc_end);
      unique case (dq_item.kind)
        K_PUSHC: begin wr0 = 1'b1; w0 = dq_item.konst; sp_nxt = sp_r + SpW'(1); end
        K_LOAD:  begin wr0 = 1'b1; w0 = lv; sp_nxt = sp_r + SpW'(1); end
        K_STORE: begin lwr = 1'b1; lw = a; sp_nxt = sp_r - SpW'(1); end
        K_POP:   sp_nxt = sp_r - SpW'(1);
        K_DUP:   begin wr0 = 1'b1; w0 = a; sp_nxt = sp_r + SpW'(1); end
        K_DUPX1: begin
          wr0 = 1'b1; w0 = a; wr1 = 1'b1; w1 = b; wr2 = 1'b1; w2 = a;
          sp_nxt = sp_r + SpW'(1);
        end
        K_ADD:   begin wr2 = 1'b1; w2 = b + a; sp_nxt = sp_r - SpW'(1); end
        K_SUB:   begin wr2 = 1'b1; w2 = b - a; sp_nxt = sp_r - SpW'(1); end
        K_MUL:   begin wr2 = 1'b1; w2 = mul; sp_nxt = sp_r - SpW'(1); end
        K_IINC:  begin lwr = 1'b1; lw = lv + {{24{dq_item.lo[7]}}, dq_item.lo}; end
        K_CAST:  begin
          wr1 = 1'b1;
          unique case (dq_item.cmd)
            OP_I2B:  w1 = {{24{a[7]}}, a[7:0]};
            OP_I2C:  w1 = {16'd0, a[15:0]};
            default: w1 = {{16{a[15]}}, a[15:0]};
          endcase
        end
        K_IF1, K_IF2, K_GOTO: begin
          sp_nxt = sp_r - SpW'(dq_item.need);
          if (cond) begin taken = 1'b1; pc_nxt = 16'(tgt); end
        end
        K_RET:   begin halted_nxt = 1'b1; pc_nxt = pc_r; end
        default: ;
      endcase
    end
    // new stack top as seen after this item
    tnew = stk_r[SIdxW'(sp_nxt - SpW'(1))];
    if (wr0 && sp_nxt == sp_r + SpW'(1)) tnew = w0;
    else if (wr1 && sp_nxt == sp_r) tnew = w1;
    else if (wr2 && sp_nxt == sp_r - SpW'(1)) tnew = w2;
    if (sp_nxt == '0) tnew = '0;
    wval = tnew;
    res_nxt.next_pc = pc_nxt;
    res_nxt.branch_taken = taken;
    res_nxt.top_value = $signed(wval);
    res_nxt.stack_depth = 5'(sp_nxt);
    res_nxt.returned = halted_nxt;
    res_nxt.fault = flt;
  end

  // state update
  always_comb begin
    full_nxt = full_r;
    if (out_pop) full_nxt = 1'b0;
    if (go) full_nxt = 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; pc_r <= '0; halted_r <= 1'b0; full_r <= 1'b0;
      for (int k = 0; k < LocalCount; k++) loc_r[k] <= '0;
    end else begin
      full_r <= full_nxt;
      if (go) begin
        sp_r <= sp_nxt; pc_r <= pc_nxt; halted_r <= halted_nxt;
        if (lwr) loc_r[li] <= lw;
      end
    end
    if (go) begin
      res_r <= res_nxt;
      if (wr2) stk_r[i2] <= w2;
      if (wr1) stk_r[i1] <= w1;
      if (wr0) stk_r[i0] <= w0;
    end
  end
  assign out_item = res_r;
  assign out_empty = !full_r;

  `JVX_ASSERT_IMP(a_sp_range, 1'b1, sp_r <= SpW'(StackDepth))
  `JVX_ASSERT_NXT(a_halt_sticky, halted_r, halted_r)
  `JVX_ASSERT_NXT(a_halt_pc, halted_r && go, $stable(pc_r) && $stable(sp_r))
  `JVX_ASSERT_IMP(a_fault_nostate, go && flt != FLT_NONE, !lwr && !wr0 && !wr1 && !wr2)
endmodule
`default_nettype wire

// ===== rtl/core/jvm_int_bytecode_executor.sv =====
// Top level of the integer bytecode executor: config register, front, back.
// Depends on jvx_pkg, jvx_front and jvx_back.
//
// Usage: push one instruction item (opcode, two operand bytes) per cycle on
// in_push while in_full is low. Each item yields exactly one result item on
// the out_ side, read with out_pop while out_empty is low.
// The decode register loads when an item is accepted, the execute stage's result
// register when the back end takes it; the result can then be popped.
// Throughput: one item per cycle while the receiver keeps popping, set by the execute
// stage that reads and writes the operand stack and locals in the same cycle.
// When the receiver stalls, the result register holds, the decode queue
// fills and in_full rises; nothing is lost.
// Reset (rst_n low, synchronous): pc, stack pointer, halt flag and all locals
// clear, the method length returns to 65535, both queues empty.
// cfg_we writes the method length at once; write it only while the block is idle.
`default_nettype none
module jvm_int_bytecode_executor import jvx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire logic      in_push,
  output logic           in_full,
  output out_item_t      out_item,
  output logic           out_empty,
  input  wire logic      out_pop,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0] meth_len_r;
  dec_item_t dq_item;
  logic dq_valid, dq_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) meth_len_r <= 16'hFFFF;
    else if (cfg_we) meth_len_r <= cfg_wdata;
  end

  jvx_front u_front (
    .clk, .rst_n, .in_item, .in_push, .in_full,
    .dq_item, .dq_valid, .dq_ready
  );
  jvx_back u_back (
    .clk, .rst_n, .meth_len(meth_len_r), .dq_item, .dq_valid, .dq_ready,
    .out_item, .out_empty, .out_pop
  );
endmodule
`default_nettype wire
